>>> design/bdeq_pkg.sv
// Shared constants and types for the bounded double-ended queue.
package bdeq_pkg;

   localparam int DEPTH = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int KIND_W = 3;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNUSED    = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  fill_count;
      logic                is_empty;
      logic                is_full;
      logic                use_rdata;
   } meta_type;

endpackage

>>> design/bdeq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bdeq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bdeq_ctrl.sv
// Pointer and count control: decodes an operation and issues its store access.
module bdeq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [bdeq_pkg::KIND_W-1:0]   kind,
   input  logic [bdeq_pkg::DATA_W-1:0]   value,
   output logic                          wr_en,
   output logic [bdeq_pkg::ADDR_W-1:0]   wr_addr,
   output logic [bdeq_pkg::DATA_W-1:0]   wr_data,
   output logic                          rd_en,
   output logic [bdeq_pkg::ADDR_W-1:0]   rd_addr,
   output bdeq_pkg::meta_type            meta
);

   localparam logic [bdeq_pkg::ADDR_W-1:0] LAST_ADDR = bdeq_pkg::ADDR_W'(bdeq_pkg::DEPTH - 1);
   localparam logic [bdeq_pkg::COUNT_W-1:0] FULL_COUNT = bdeq_pkg::COUNT_W'(bdeq_pkg::DEPTH);

   logic [bdeq_pkg::ADDR_W-1:0]  head_ff, head_in;
   logic [bdeq_pkg::ADDR_W-1:0]  tail_ff, tail_in;
   logic [bdeq_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [bdeq_pkg::ADDR_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;
   logic                         empty, full;
   logic [bdeq_pkg::STATUS_W-1:0] status;
   logic                         use_rdata;

   assign empty = (count_ff == '0);
   assign full = (count_ff == FULL_COUNT);
   assign head_inc = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? LAST_ADDR : head_ff - 1'b1;
   assign tail_inc = (tail_ff == LAST_ADDR) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? LAST_ADDR : tail_ff - 1'b1;
   assign wr_data = value;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      wr_en = 1'b0;
      wr_addr = tail_ff;
      rd_en = 1'b0;
      rd_addr = head_ff;
      status = bdeq_pkg::STATUS_OK;
      use_rdata = 1'b0;
      unique case (kind)
         bdeq_pkg::KIND_PUSH_BACK: begin
            if (full) begin
               status = bdeq_pkg::STATUS_OVERFLOW;
            end else begin
               wr_en = fire;
               wr_addr = tail_ff;
               tail_in = tail_inc;
               count_in = count_ff + 1'b1;
            end
         end
         bdeq_pkg::KIND_PUSH_FRONT: begin
            if (full) begin
               status = bdeq_pkg::STATUS_OVERFLOW;
            end else begin
               wr_en = fire;
               wr_addr = head_dec;
               head_in = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         bdeq_pkg::KIND_POP_FRONT: begin
            if (empty) begin
               status = bdeq_pkg::STATUS_UNDERFLOW;
            end else begin
               rd_en = fire;
               rd_addr = head_ff;
               use_rdata = 1'b1;
               head_in = head_inc;
               count_in = count_ff - 1'b1;
            end
         end
         bdeq_pkg::KIND_POP_BACK: begin
            if (empty) begin
               status = bdeq_pkg::STATUS_UNDERFLOW;
            end else begin
               rd_en = fire;
               rd_addr = tail_dec;
               use_rdata = 1'b1;
               tail_in = tail_dec;
               count_in = count_ff - 1'b1;
            end
         end
         bdeq_pkg::KIND_PEEK_FRONT: begin
            if (empty) begin
               status = bdeq_pkg::STATUS_UNDERFLOW;
            end else begin
               rd_en = fire;
               rd_addr = head_ff;
               use_rdata = 1'b1;
            end
         end
         bdeq_pkg::KIND_CLEAR: begin
            head_in = '0;
            tail_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      meta.status = status;
      meta.fill_count = count_in;
      meta.is_empty = (count_in == '0);
      meta.is_full = (count_in == FULL_COUNT);
      meta.use_rdata = use_rdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else if (fire) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> design/bdeq_out.sv
// Result pipeline: captures the store read data, then holds the result beat.
module bdeq_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  bdeq_pkg::meta_type            meta,
   input  logic [bdeq_pkg::DATA_W-1:0]   rd_data,
   output logic                          in_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bdeq_pkg::DATA_W-1:0]   rsp_read_value,
   output bdeq_pkg::meta_type            rsp_meta
);

   logic                        s1_valid_ff, s1_valid_in;
   bdeq_pkg::meta_type          s1_meta_ff;
   logic                        s2_valid_ff, s2_valid_in;
   bdeq_pkg::meta_type          s2_meta_ff;
   logic [bdeq_pkg::DATA_W-1:0] s2_value_ff;
   logic                        s2_free, s1_adv;

   assign s2_free = !s2_valid_ff || rsp_ready;
   assign s1_adv = s1_valid_ff && s2_free;
   assign in_ready = !s1_valid_ff || s2_free;
   assign s1_valid_in = fire || (s1_valid_ff && !s1_adv);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_meta_ff <= meta;
      end
      if (s1_adv) begin
         s2_meta_ff <= s1_meta_ff;
         s2_value_ff <= s1_meta_ff.use_rdata ? rd_data : '0;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_read_value = s2_value_ff;
   assign rsp_meta = s2_meta_ff;

endmodule

>>> design/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
//
//   channel   | handshake             | payload
//   req_      | req_valid / req_ready | kind, value
//   rsp_      | rsp_valid / rsp_ready | read_value, status, fill_count, is_empty, is_full
//
// One operation is accepted per cycle unless the output stalls it.
// The store is a single memory with one write and one registered read port.
// Pointers and count update at acceptance, so back-to-back operations see them at once.
// A stalled result is held in the output register while one more operation waits behind it.
// Reset clears the pointers and count; store contents are not cleared.
module bounded_double_ended_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bdeq_pkg::KIND_W-1:0]           req_kind,
   input  logic signed [bdeq_pkg::DATA_W-1:0]    req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [bdeq_pkg::DATA_W-1:0]    rsp_read_value,
   output logic [bdeq_pkg::STATUS_W-1:0]         rsp_status,
   output logic [bdeq_pkg::COUNT_W-1:0]          rsp_fill_count,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_is_full
);

   logic                        fire;
   logic                        wr_en, rd_en;
   logic [bdeq_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   logic [bdeq_pkg::DATA_W-1:0] wr_data, rd_data, out_value;
   bdeq_pkg::meta_type          meta, out_meta;

   assign fire = req_valid && req_ready;

   bdeq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .kind    (req_kind),
      .value   (req_value),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .meta    (meta)
   );

   bdeq_ram #(
      .WIDTH (bdeq_pkg::DATA_W),
      .DEPTH (bdeq_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bdeq_out u_out (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .meta           (meta),
      .rd_data        (rd_data),
      .in_ready       (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (out_value),
      .rsp_meta       (out_meta)
   );

   assign rsp_read_value = out_value;
   assign rsp_status = out_meta.status;
   assign rsp_fill_count = out_meta.fill_count;
   assign rsp_is_empty = out_meta.is_empty;
   assign rsp_is_full = out_meta.is_full;

endmodule

>>> design/bdeq_checker.sv
// Port-level checks for the bounded double-ended queue and their binding.
module bdeq_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [bdeq_pkg::DATA_W-1:0]   rsp_read_value,
   input logic [bdeq_pkg::STATUS_W-1:0]        rsp_status,
   input logic [bdeq_pkg::COUNT_W-1:0]         rsp_fill_count,
   input logic                                 rsp_is_empty,
   input logic                                 rsp_is_full
);

   localparam logic [bdeq_pkg::COUNT_W-1:0] FULL_COUNT = bdeq_pkg::COUNT_W'(bdeq_pkg::DEPTH);

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_fill_count == '0)))
      else $error("empty flag disagrees with fill count");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_full == (rsp_fill_count == FULL_COUNT)))
      else $error("full flag disagrees with fill count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fill_count <= FULL_COUNT && rsp_status != bdeq_pkg::STATUS_UNUSED))
      else $error("fill count or status out of range");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bdeq_pkg::STATUS_OK) |-> (rsp_read_value == '0))
      else $error("error beat carries a nonzero value");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_fill_count)))
      else $error("stalled result beat changed");

endmodule

bind bounded_double_ended_queue bdeq_checker u_bdeq_checker (.*);
